/* hw/rtl/b64e_pkg.sv */
package b64e_pkg;

   localparam logic [6:0] PAD_CHAR   = 7'h3D;
   localparam logic [6:0] PLUS_CHAR  = 7'h2B;
   localparam logic [6:0] SLASH_CHAR = 7'h2F;
   localparam int         MAX_CHARS  = 4;
   localparam int         QUEUE_DEPTH = 2;

   typedef logic [6:0] char_type;
   typedef logic [2:0] count_type;   // 1..4 characters per record
   typedef logic [1:0] index_type;
   typedef logic [1:0] qcount_type;  // 0..QUEUE_DEPTH

   // characters produced by one input word
   typedef struct packed {
      char_type [MAX_CHARS-1:0] chars;
      count_type                count;
      logic                     last;
   } record_type;

   function automatic char_type sextet_char(input logic [5:0] v);
      char_type c;
      if (v < 6'd26) begin
         c = 7'h41 + 7'(v);
      end else if (v < 6'd52) begin
         c = 7'h61 + 7'(v - 6'd26);
      end else if (v < 6'd62) begin
         c = 7'h30 + 7'(v - 6'd52);
      end else if (v == 6'd62) begin
         c = PLUS_CHAR;
      end else begin
         c = SLASH_CHAR;
      end
      return c;
   endfunction

endpackage

/* hw/rtl/b64e_if.sv */
interface b64e_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       final_byte;

   modport source(output valid, output data_byte, output final_byte, input ready);
   modport sink(input valid, input data_byte, input final_byte, output ready);
endinterface

interface b64e_rsp_if;
   logic       valid;
   logic       ready;
   logic [6:0] out_char;
   logic       last_char;

   modport source(output valid, output out_char, output last_char, input ready);
   modport sink(input valid, input out_char, input last_char, output ready);
endinterface

/* hw/rtl/b64e_front.sv */
module b64e_front (
   input  logic                  clock,
   input  logic                  reset,
   b64e_req_if.sink              req_if,
   input  logic                  q_full,
   output logic                  push,
   output b64e_pkg::record_type  push_rec,
   output logic [1:0]            phase
);

   logic [1:0] phase_ff, phase_in;
   logic [3:0] left_ff, left_in;

   always_comb begin
      logic [7:0] b;
      logic [1:0] nphase;
      logic [3:0] nleft;
      b         = req_if.data_byte;
      push_rec  = '0;
      nphase    = 2'd1;
      nleft     = 4'd0;
      case (phase_ff)
         2'd1: begin
            push_rec.chars[0] = b64e_pkg::sextet_char({left_ff[1:0], b[7:4]});
            push_rec.count    = 3'd1;
            nphase            = 2'd2;
            nleft             = b[3:0];
         end
         2'd2: begin
            push_rec.chars[0] = b64e_pkg::sextet_char({left_ff, b[7:6]});
            push_rec.chars[1] = b64e_pkg::sextet_char(b[5:0]);
            push_rec.count    = 3'd2;
            nphase            = 2'd0;
            nleft             = 4'd0;
         end
         default: begin
            // unreachable phase three behaves as phase zero
            push_rec.chars[0] = b64e_pkg::sextet_char(b[7:2]);
            push_rec.count    = 3'd1;
            nphase            = 2'd1;
            nleft             = {2'b00, b[1:0]};
         end
      endcase
      if (req_if.final_byte) begin
         if (nphase == 2'd1) begin
            push_rec.chars[1] = b64e_pkg::sextet_char({nleft[1:0], 4'b0000});
            push_rec.chars[2] = b64e_pkg::PAD_CHAR;
            push_rec.chars[3] = b64e_pkg::PAD_CHAR;
            push_rec.count    = 3'd4;
         end else if (nphase == 2'd2) begin
            push_rec.chars[1] = b64e_pkg::sextet_char({nleft, 2'b00});
            push_rec.chars[2] = b64e_pkg::PAD_CHAR;
            push_rec.count    = 3'd3;
         end
         push_rec.last = 1'b1;
         nphase        = 2'd0;
         nleft         = 4'd0;
      end
      req_if.ready = !q_full;
      push         = req_if.valid && !q_full;
      phase_in     = push ? nphase : phase_ff;
      left_in      = push ? nleft : left_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= 2'd0;
         left_ff  <= 4'd0;
      end else begin
         phase_ff <= phase_in;
         left_ff  <= left_in;
      end
   end

   assign phase = phase_ff;

endmodule

/* hw/rtl/b64e_queue.sv */
module b64e_queue (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   input  b64e_pkg::record_type  push_rec,
   input  logic                  pop,
   output b64e_pkg::record_type  head_rec,
   output logic                  empty,
   output logic                  full,
   output b64e_pkg::qcount_type  count
);

   b64e_pkg::record_type mem_ff [b64e_pkg::QUEUE_DEPTH];
   logic                 wr_ptr_ff, wr_ptr_in;
   logic                 rd_ptr_ff, rd_ptr_in;
   b64e_pkg::qcount_type count_ff, count_in;

   always_comb begin
      wr_ptr_in = push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 2'd1;
      end else if (pop && !push) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_rec;
      end
   end

   assign head_rec = mem_ff[rd_ptr_ff];
   assign empty    = (count_ff == 2'd0);
   assign full     = (count_ff == 2'(b64e_pkg::QUEUE_DEPTH));
   assign count    = count_ff;

endmodule

/* hw/rtl/b64e_back.sv */
module b64e_back (
   input  logic                  clock,
   input  logic                  reset,
   input  b64e_pkg::record_type  head_rec,
   input  logic                  q_empty,
   output logic                  pop,
   b64e_rsp_if.source            rsp_if
);

   logic                  valid_ff, valid_in;
   b64e_pkg::char_type    char_ff, char_in;
   logic                  last_ff, last_in;
   b64e_pkg::index_type   idx_ff, idx_in;

   always_comb begin
      logic load;
      logic at_end;
      load     = !valid_ff || rsp_if.ready;
      at_end   = (idx_ff == 2'(head_rec.count - 3'd1));
      valid_in = valid_ff && !rsp_if.ready;
      char_in  = char_ff;
      last_in  = last_ff;
      idx_in   = idx_ff;
      pop      = 1'b0;
      if (load && !q_empty) begin
         valid_in = 1'b1;
         char_in  = head_rec.chars[idx_ff];
         last_in  = head_rec.last && at_end;
         if (at_end) begin
            pop    = 1'b1;
            idx_in = '0;
         end else begin
            idx_in = idx_ff + 2'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         idx_ff   <= '0;
      end else begin
         valid_ff <= valid_in;
         idx_ff   <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      char_ff <= char_in;
      last_ff <= last_in;
   end

   assign rsp_if.valid     = valid_ff;
   assign rsp_if.out_char  = char_ff;
   assign rsp_if.last_char = last_ff;

endmodule

/* hw/rtl/base64_encoder.sv */
// Path: a word's characters are written into a queue entry, then loaded one
// at a time into the output register, which drives the output.
// Throughput: one character per cycle while the output is ready; a word yields
// 1 or 2 characters (up to 4 on a final word), drained by the single output
// register from a two-entry queue, which takes new words while not full.
// Reset: synchronous, active high; clears group phase, leftover bits and queue.
module base64_encoder (
   input  logic       clock,
   input  logic       reset,
   b64e_req_if.sink   req_if,
   b64e_rsp_if.source rsp_if
);

   logic                 push;
   logic                 pop;
   logic                 q_empty;
   logic                 q_full;
   logic [1:0]           phase;
   b64e_pkg::record_type push_rec;
   b64e_pkg::record_type head_rec;
   b64e_pkg::qcount_type q_count;

   b64e_front u_front (
      .clock    (clock),
      .reset    (reset),
      .req_if   (req_if),
      .q_full   (q_full),
      .push     (push),
      .push_rec (push_rec),
      .phase    (phase)
   );

   b64e_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_rec (push_rec),
      .pop      (pop),
      .head_rec (head_rec),
      .empty    (q_empty),
      .full     (q_full),
      .count    (q_count)
   );

   b64e_back u_back (
      .clock    (clock),
      .reset    (reset),
      .head_rec (head_rec),
      .q_empty  (q_empty),
      .pop      (pop),
      .rsp_if   (rsp_if)
   );

   // a final word always closes the group
   a_final_resets_phase: assert property (@(posedge clock) disable iff (reset)
      req_if.valid && req_if.ready && req_if.final_byte |=> phase == 2'd0)
      else $error("group phase not cleared after final word");

   a_queue_bound: assert property (@(posedge clock) disable iff (reset)
      q_count <= 2'(b64e_pkg::QUEUE_DEPTH))
      else $error("queue count out of range");

   a_no_pop_empty: assert property (@(posedge clock) disable iff (reset)
      pop |-> !q_empty)
      else $error("pop from empty queue");

   a_phase_two_next: assert property (@(posedge clock) disable iff (reset)
      push && !req_if.final_byte && phase == 2'd1 |=> phase == 2'd2)
      else $error("phase did not advance");

endmodule
